@@ hdl/mersenne_twister_generator_unit_defines.svh @@
// Assertion helpers for the generator unit.
// Define SYNTH to compile the checks out.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Combinational implication checked at every clock edge out of reset.
`define MTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mtg assertion failed");

// Condition in one cycle implies a condition in the next cycle.
`define MTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mtg assertion failed");

`else

`define MTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/mtg_pkg.sv @@
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = 10;

    localparam logic [31:0] TWIST_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT_MASK = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS_MASK = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT     = 32'd1812433253;
    localparam logic [31:0] SEED_DEFAULT  = 32'd5489;

    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STATE_WORDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_FETCH,
        ST_TWIST
    } t_state;

    // state memory write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } t_ram_wr;

    // regenerate one state word from the current, next and far words
    function automatic logic [31:0] f_twist(input logic [31:0] cur,
                                            input logic [31:0] nxt,
                                            input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] v;
        y = (cur & HIGH_BIT_MASK) | (nxt & LOW_BITS_MASK);
        v = far ^ {1'b0, y[31:1]};
        if (y[0]) begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    // output tempering
    function automatic logic [31:0] f_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

@@ hdl/mersenne_twister_generator_unit.sv @@
// 32-bit MT19937 generator. Each input beat requests one tempered word; with
// tdata bit 0 (reseed) set, or on the first request after reset, the 624-word
// state is first filled from the seed register. A normal request is accepted,
// then twisted, tempered and written back; the next word's "next" and
// "far" state words are read from the dual-read-port state memory during the
// accept cycle, and the current word is held in a register from the previous
// read. In a seeding request the fill alternates a multiply and an add/write
// step per word through the registered 32x32 seed multiplier, followed by a
// fetch step. The state memory is not cleared at reset. The seed register is
// written with i_cfg_we and takes effect at the next seeding.
`include "mersenne_twister_generator_unit_defines.svh"

module mersenne_twister_generator_unit
    import mtg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: seed register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [0] reseed, [7:1] zero
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [31:0] random_word
);

    t_state            r_state;
    t_state            n_state;
    logic [31:0]       r_seed;
    logic              r_need_seed;
    logic [ADDR_W-1:0] r_k;
    logic [ADDR_W-1:0] r_seed_idx;
    logic [31:0]       r_prev;
    logic [31:0]       r_prod;
    logic [31:0]       r_cur;
    logic              r_out_valid;
    logic [31:0]       r_out_data;

    logic              s_accept;
    logic              s_do_seed;
    logic [ADDR_W-1:0] s_addr_nxt;
    logic [ADDR_W-1:0] s_addr_far;
    logic [ADDR_W:0]   s_far_sum;
    logic [31:0]       s_seed_val;
    logic [31:0]       s_twist_val;
    logic [31:0]       s_rd_nxt;
    logic [31:0]       s_rd_far;
    t_ram_wr           s_wr;

    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_do_seed = i_s_axis_tdata[0] || r_need_seed;

    // read addresses for word k: k+1 and k+397, both modulo the state size
    assign s_addr_nxt = (r_k == LAST_IDX) ? '0 : r_k + ADDR_W'(1);
    assign s_far_sum  = {1'b0, r_k} + (ADDR_W + 1)'(TWIST_OFFSET);
    assign s_addr_far = (s_far_sum >= (ADDR_W + 1)'(STATE_WORDS))
                      ? ADDR_W'(s_far_sum - (ADDR_W + 1)'(STATE_WORDS))
                      : ADDR_W'(s_far_sum);

    assign s_seed_val  = r_prod + {{(32 - ADDR_W){1'b0}}, r_seed_idx};
    assign s_twist_val = f_twist(r_cur, s_rd_nxt, s_rd_far);

    mtg_state_ram u_ram (
        .i_clk       (i_clk),
        .i_wr        (s_wr),
        .i_rd_addr_a (s_addr_nxt),
        .i_rd_addr_b (s_addr_far),
        .o_rd_data_a (s_rd_nxt),
        .o_rd_data_b (s_rd_far)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = s_do_seed ? ST_SEED_MUL : ST_TWIST;
                end
            end
            ST_SEED_MUL: n_state = ST_SEED_ADD;
            ST_SEED_ADD: begin
                n_state = (r_seed_idx == LAST_IDX) ? ST_FETCH : ST_SEED_MUL;
            end
            ST_FETCH:    n_state = ST_TWIST;
            ST_TWIST:    n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs: ready and memory writes
    always_comb begin
        o_s_axis_tready = 1'b0;
        s_wr            = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = !r_out_valid || i_m_axis_tready;
                if (s_accept && s_do_seed) begin
                    s_wr.en   = 1'b1;
                    s_wr.addr = '0;
                    s_wr.data = r_seed;
                end
            end
            ST_SEED_ADD: begin
                s_wr.en   = 1'b1;
                s_wr.addr = r_seed_idx;
                s_wr.data = s_seed_val;
            end
            ST_TWIST: begin
                s_wr.en   = 1'b1;
                s_wr.addr = r_k;
                s_wr.data = s_twist_val;
            end
            default: begin
                s_wr = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= SEED_DEFAULT;
            r_need_seed <= 1'b1;
            r_k         <= '0;
            r_seed_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (s_accept && s_do_seed) begin
                r_need_seed <= 1'b0;
                r_k         <= '0;
                r_seed_idx  <= ADDR_W'(1);
            end
            if (r_state == ST_SEED_ADD) begin
                r_seed_idx <= r_seed_idx + ADDR_W'(1);
            end
            if (r_state == ST_TWIST) begin
                r_k <= s_addr_nxt;
            end
            // output beat register
            if (r_state == ST_TWIST) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_accept && s_do_seed) begin
            r_prev <= r_seed;
            r_cur  <= r_seed;
        end
        if (r_state == ST_SEED_MUL) begin
            r_prod <= 32'(SEED_MULT * (r_prev ^ (r_prev >> 30)));
        end
        if (r_state == ST_SEED_ADD) begin
            r_prev <= s_seed_val;
        end
        if (r_state == ST_TWIST) begin
            r_cur      <= s_rd_nxt;
            r_out_data <= f_temper(s_twist_val);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // word pointer always inside the state
    `MTG_ASSERT_IMP(a_k_range, i_clk, i_rst_n, 1'b1, r_k <= LAST_IDX)
    // output slot is free whenever a word is produced
    `MTG_ASSERT_IMP(a_out_free, i_clk, i_rst_n, r_state == ST_TWIST, !r_out_valid)
    // an accepted request either seeds or twists right away
    `MTG_ASSERT_NXT(a_accept_next, i_clk, i_rst_n, s_accept,
        r_state == ST_SEED_MUL || r_state == ST_TWIST)
    // seed fill index stays within 1..623 while filling
    `MTG_ASSERT_IMP(a_seed_idx, i_clk, i_rst_n,
        r_state == ST_SEED_MUL || r_state == ST_SEED_ADD,
        r_seed_idx != '0 && r_seed_idx <= LAST_IDX)
    // a new beat appears only after the twist cycle
    `MTG_ASSERT_NXT(a_out_src, i_clk, i_rst_n,
        !o_m_axis_tvalid && r_state != ST_TWIST, !o_m_axis_tvalid)

endmodule

@@ hdl/mtg_state_ram.sv @@
module mtg_state_ram
    import mtg_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [31:0]       o_rd_data_a,
    output logic [31:0]       o_rd_data_b
);

    logic [31:0] r_mem [STATE_WORDS];
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

@@ tb/mersenne_twister_generator_unit_test.sv @@
`timescale 1ns / 100ps

module mersenne_twister_generator_unit_test
    import mtg_pkg::*;
;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    // Tracks the generator state and the queue of tempered words still owed
    class tempered_word_tracker;
        logic [31:0] state_words [STATE_WORDS];
        int unsigned word_pos;
        bit          seeded;
        logic [31:0] seed_word;
        logic [31:0] owed_words [$];
        int unsigned failures;

        function new();
            word_pos  = STATE_WORDS;
            seeded    = 1'b0;
            seed_word = SEED_DEFAULT;
            failures  = 0;
        endfunction

        function void set_seed(logic [31:0] value);
            seed_word = value;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        // multiplier recurrence over the whole state
        function void fill_state();
            logic [31:0] prev;
            state_words[0] = seed_word;
            for (int i = 1; i < STATE_WORDS; i++) begin
                prev = state_words[i-1];
                state_words[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
            end
            word_pos = STATE_WORDS;
        endfunction

        // regenerate all state words in place
        function void regenerate_state();
            logic [31:0] mixed;
            logic [31:0] fresh;
            for (int k = 0; k < STATE_WORDS; k++) begin
                mixed = (state_words[k] & HIGH_BIT_MASK) |
                        (state_words[(k + 1) % STATE_WORDS] & LOW_BITS_MASK);
                fresh = state_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (mixed >> 1);
                if (mixed[0]) begin
                    fresh = fresh ^ TWIST_MATRIX;
                end
                state_words[k] = fresh;
            end
            word_pos = 0;
        endfunction

        function logic [31:0] tempered(logic [31:0] raw);
            logic [31:0] t;
            t = raw ^ (raw >> 11);
            t = t ^ ((t << 7) & TEMPER_B);
            t = t ^ ((t << 15) & TEMPER_C);
            return t ^ (t >> 18);
        endfunction

        // one accepted request owes one word
        function void note_request(bit reseed);
            if (reseed || !seeded) begin
                fill_state();
                seeded = 1'b1;
            end
            if (word_pos >= STATE_WORDS) begin
                regenerate_state();
            end
            owed_words.push_back(tempered(state_words[word_pos]));
            word_pos = (word_pos + 1) & 10'h3ff;
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (owed_words.size() == 0) begin
                failures++;
                $display("%0t: unexpected random_word, expected none actual %h", $time, got);
                return;
            end
            want = owed_words.pop_front();
            if (got !== want) begin
                failures++;
                $display("%0t: random_word mismatch, expected %h actual %h", $time, want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;

    tempered_word_tracker words = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_wanted = 1'b0;
    int unsigned cycle_count = 0;

    mersenne_twister_generator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),          // [0] reseed, [7:1] zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)    // [31:0] random_word
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("mersenne_twister_generator_unit_test failed");
            $finish;
        end
    end

    // result side: check each beat, then pick next tready
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_tready) begin
                words.check_word(o_m_axis_tdata);
            end
            if (hold_wanted) begin
                hold_wanted = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // offer one request beat, with an optional random gap first
    task automatic send_request(input bit reseed);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, reseed};
        do @(posedge i_clk); while (!o_s_axis_tready);
        words.note_request(reseed);
    endtask

    // stop offering and wait for every owed word
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (words.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        words.set_seed(value);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int unsigned phase_items;
        int unsigned reseed_odds;
        bit          first_reseed;
        logic [31:0] phase_seed;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default seed picked up by the first request without reseed
        repeat (5) send_request(1'b0);
        send_request(1'b1);
        // zero seed
        load_seed(32'h0000_0000);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        // all-ones seed
        load_seed(32'hffff_ffff);
        send_request(1'b1);
        send_request(1'b0);
        // reseed on back-to-back requests
        repeat (3) send_request(1'b1);
        // new seed is ignored until the next reseed
        load_seed(32'h0000_0001);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);

        // random phases with different idling
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    phase_seed = $urandom; first_reseed = 1'b1;
                    phase_items = 650; reseed_odds = 0;
                end
                1: begin
                    send_idle_pct = 53; recv_stall_pct = 0;
                    phase_seed = $urandom; first_reseed = 1'b0;
                    phase_items = 300; reseed_odds = 150;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 53;
                    phase_seed = 32'hffff_ffff; first_reseed = 1'b1;
                    phase_items = 300; reseed_odds = 150;
                end
                default: begin
                    send_idle_pct = 19; recv_stall_pct = 19;
                    phase_seed = $urandom; first_reseed = 1'b1;
                    phase_items = 300; reseed_odds = 150;
                end
            endcase
            load_seed(phase_seed);
            send_request(first_reseed);
            for (int n = 1; n < phase_items; n++) begin
                // long receiver hold while requests keep coming
                if (p == 0 && n == 100) begin
                    hold_wanted = 1'b1;
                end
                // sender waits for the pipe to empty once
                if (p == 1 && n == 150) begin
                    drain_results();
                end
                send_request(reseed_odds != 0 && $urandom_range(reseed_odds - 1) == 0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (words.failures == 0 && words.pending() == 0) begin
            $display("mersenne_twister_generator_unit_test passed");
        end else begin
            $display("mersenne_twister_generator_unit_test failed");
        end
        $finish;
    end

endmodule
